FILE: rtl/lbrb_pkg.sv
`timescale 1ns / 1ps

package lbrb_pkg;

    localparam int DEPTH = 4096;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic {
        CMD_APPEND = 1'b0,
        CMD_TAKE   = 1'b1
    } cmd_t;

    // one unit of work for the back end: a store write or a store read
    typedef struct packed {
        cmd_t            op;
        logic [AW-1:0]   addr;
        logic [7:0]      data;
        logic            hit;      // take found a stored byte
        logic            dropped;
    } queue_entry_t;

    typedef struct packed {
        logic [CW-1:0]   fill;
        logic            overrun;
    } front_status_t;

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: rtl/lbrb_front.sv
`timescale 1ns / 1ps

module lbrb_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic                  cmd_in,
    input  logic [7:0]            byte_in,
    input  logic                  msg_start,
    output logic                  push,
    output lbrb_pkg::queue_entry_t push_entry,
    output lbrb_pkg::front_status_t status
);
    import lbrb_pkg::*;

    logic [AW-1:0] wr_idx_reg, wr_idx_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          overrun_reg, overrun_next;
    logic [CW-1:0] msg_len_reg, msg_len_next;
    logic [CW-1:0] msg_len_cur;
    logic          discard;
    logic          full;
    cmd_t          op;

    assign op          = cmd_t'(cmd_in);
    assign full        = (fill_reg == CW'(DEPTH));
    assign msg_len_cur = msg_start ? '0 : msg_len_reg;
    assign discard     = (op == CMD_APPEND) && (msg_len_cur >= CW'(DEPTH));

    always_comb begin
        wr_idx_next  = wr_idx_reg;
        rd_idx_next  = rd_idx_reg;
        fill_next    = fill_reg;
        overrun_next = overrun_reg;
        msg_len_next = msg_len_reg;
        push         = 1'b0;
        push_entry.op      = op;
        push_entry.addr    = wr_idx_reg;
        push_entry.data    = byte_in;
        push_entry.hit     = 1'b0;
        push_entry.dropped = 1'b0;
        if (accept) begin
            case (op)
                CMD_APPEND: begin
                    // message past the length clamp is dropped with no state change
                    if (!discard) begin
                        push         = 1'b1;
                        wr_idx_next  = next_idx(wr_idx_reg);
                        msg_len_next = msg_len_cur + 1'b1;
                        if (full) begin
                            rd_idx_next  = next_idx(rd_idx_reg);
                            overrun_next = 1'b1;
                        end else begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                end
                CMD_TAKE: begin
                    push            = 1'b1;
                    push_entry.addr = rd_idx_reg;
                    if (fill_reg != '0) begin
                        push_entry.hit     = 1'b1;
                        push_entry.dropped = overrun_reg;
                        overrun_next       = 1'b0;
                        rd_idx_next        = next_idx(rd_idx_reg);
                        fill_next          = fill_reg - 1'b1;
                    end
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            fill_reg    <= '0;
            overrun_reg <= 1'b0;
            msg_len_reg <= '0;
        end else begin
            wr_idx_reg  <= wr_idx_next;
            rd_idx_reg  <= rd_idx_next;
            fill_reg    <= fill_next;
            overrun_reg <= overrun_next;
            msg_len_reg <= msg_len_next;
        end
    end

    assign status.fill    = fill_reg;
    assign status.overrun = overrun_reg;

endmodule

FILE: rtl/lbrb_queue.sv
`timescale 1ns / 1ps

module lbrb_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  lbrb_pkg::queue_entry_t push_entry,
    output logic                   full,
    output logic                   not_empty,
    input  logic                   pop,
    output lbrb_pkg::queue_entry_t head
);
    import lbrb_pkg::*;

    queue_entry_t   slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign full      = (count_reg == QCW'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/lbrb_back.sv
`timescale 1ns / 1ps

module lbrb_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   head_valid,
    input  lbrb_pkg::queue_entry_t head,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             byte_out,
    output logic                   out_valid,
    output logic                   dropped
);
    import lbrb_pkg::*;

    logic [7:0] store [DEPTH];
    logic [7:0] rdata_reg;
    logic       m_valid_reg, m_valid_next;
    logic       hit_reg;
    logic       dropped_reg;
    logic       is_take;

    assign is_take = (head.op == CMD_TAKE);
    // writes drain freely; a take waits for the output register to free up
    assign pop = head_valid && (!is_take || !m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (pop && !is_take) begin
            store[head.addr] <= head.data;
        end
        if (pop && is_take && head.hit) begin
            rdata_reg <= store[head.addr];
        end
        if (pop && is_take) begin
            hit_reg     <= head.hit;
            dropped_reg <= head.dropped;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop && is_take) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid  = m_valid_reg;
    assign out_valid = hit_reg;
    assign byte_out  = hit_reg ? rdata_reg : 8'd0;
    assign dropped   = hit_reg & dropped_reg;

endmodule

FILE: rtl/lossy_byte_ring_buffer_unit.sv
`timescale 1ns / 1ps
// A take reaches m_* through the command queue and output register; appends give no item.
// Throughput: one item per cycle unless m_tready holds a take, set by the single-port
// byte store in the back end (one write or one read per cycle), fed by a two-entry queue.
// Reset (aresetn low, synchronous) empties the buffer, queue and output register;
// store contents are left as they are and are never read before being written.
module lossy_byte_ring_buffer_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_in
    input  logic [1:0] s_tuser,   // [0] cmd, [1] msg_start
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] byte_out
    output logic [1:0] m_tuser    // [0] out_valid, [1] dropped
);
    import lbrb_pkg::*;

    logic          accept;
    logic          push;
    queue_entry_t  push_entry;
    front_status_t status;
    logic          q_full;
    logic          q_not_empty;
    logic          pop;
    queue_entry_t  head;
    logic          out_valid;
    logic          dropped;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    lbrb_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .cmd_in     (s_tuser[0]),
        .byte_in    (s_tdata),
        .msg_start  (s_tuser[1]),
        .push       (push),
        .push_entry (push_entry),
        .status     (status)
    );

    lbrb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .pop        (pop),
        .head       (head)
    );

    lbrb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_not_empty),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .byte_out   (m_tdata),
        .out_valid  (out_valid),
        .dropped    (dropped)
    );

    assign m_tuser = {dropped, out_valid};

    // an overrun leaves the buffer full until the next take clears the flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.overrun |-> (status.fill == CW'(DEPTH)))
        else $error("overrun flag set while buffer not full");

    assert property (@(posedge aclk) disable iff (!aresetn)
        status.fill <= CW'(DEPTH))
        else $error("fill count beyond depth");

    // an empty take carries zero byte and no dropped flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'd0 && !m_tuser[1]))
        else $error("empty take result not cleared");

    // a full queue blocks the input until the back end drains it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_full && !pop) |=> !s_tready)
        else $error("queue full but input ready");

endmodule
